// ===== rtl/ppma_pkg.sv =====
// Package for the path point moving-average smoother.
// Point layout, field widths and default sizes shared by every rtl file.
package ppma_pkg;

  localparam int HALF_DEFAULT        = 2;
  localparam int QUEUE_DEPTH_DEFAULT = 2;
  localparam int COORD_W             = 32;
  localparam int HEAD_W              = 16;

  // x in the lowest bits, then y, then heading
  typedef struct packed {
    logic signed [HEAD_W-1:0]  heading;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] x;
  } point_t;

  localparam int POINT_W = $bits(point_t);
  localparam int TDATA_W = ((POINT_W + 7) / 8) * 8;

endpackage

// ===== rtl/ppma_front.sv =====
// Front end: takes input beats, counts points of the current path and tags each beat.
// Depends on ppma_pkg.
module ppma_front #(
  parameter int HALF = ppma_pkg::HALF_DEFAULT,
  localparam int DEPTH = 2 * HALF + 2,
  localparam int K_W = $clog2(DEPTH + 1)
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [ppma_pkg::TDATA_W-1:0] s_tdata,  // x, y, heading
  input  logic                         s_tlast,  // is_last
  output logic                         job_valid,
  input  logic                         job_ready,
  output ppma_pkg::point_t             job_point,
  output logic                         job_last,
  output logic [K_W-1:0]               job_k
);
  import ppma_pkg::*;

  logic [K_W-1:0] points_seen;

  assign s_tready  = job_ready;
  assign job_valid = s_tvalid;
  assign job_point = point_t'(s_tdata[POINT_W-1:0]);
  assign job_last  = s_tlast;
  assign job_k     = points_seen;

  always_ff @(posedge clk) begin
    if (rst) begin
      points_seen <= '0;
    end else if (s_tvalid && job_ready) begin
      if (s_tlast) begin
        points_seen <= '0;
      end else if (points_seen != K_W'(DEPTH)) begin
        points_seen <= points_seen + K_W'(1);
      end
    end
  end

endmodule

// ===== rtl/ppma_queue.sv =====
// Small first-in first-out queue between the front end and the back end.
// No package dependency beyond the default depth.
module ppma_queue #(
  parameter int W     = 1,
  parameter int DEPTH = ppma_pkg::QUEUE_DEPTH_DEFAULT,
  localparam int PTR_W = $clog2(DEPTH),
  localparam int CNT_W = $clog2(DEPTH + 1)
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  input  logic [W-1:0] in_data,
  output logic         out_valid,
  input  logic         out_ready,
  output logic [W-1:0] out_data
);

  logic [W-1:0]     mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             push;
  logic             pop;

  assign in_ready  = (count != CNT_W'(DEPTH));
  assign out_valid = (count != '0);
  assign out_data  = mem[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

// ===== rtl/ppma_div.sv =====
// Bit-serial signed divider, one quotient bit per cycle, truncating toward zero.
// Divisor is unsigned and non-zero. No package dependency beyond defaults.
module ppma_div #(
  parameter int W  = ppma_pkg::COORD_W,
  parameter int DW = 4,
  localparam int LW = $clog2(W + 1)
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic signed [W-1:0] dividend,
  input  logic [DW-1:0]       divisor,
  output logic                done,
  output logic signed [W-1:0] quotient
);

  logic          busy;
  logic [LW-1:0] left;
  logic [W-1:0]  q;
  logic [DW:0]   rem;
  logic [DW:0]   rem_sh;
  logic [DW-1:0] den;
  logic          neg;
  logic          ge;
  logic [W-1:0]  dvd_u;
  logic [W-1:0]  mag;

  assign dvd_u    = dividend;
  assign mag      = dvd_u[W-1] ? (~dvd_u + W'(1)) : dvd_u;
  assign rem_sh   = {rem[DW-1:0], q[W-1]};
  assign ge       = (rem_sh >= {1'b0, den});
  assign quotient = neg ? (~q + W'(1)) : q;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        neg  <= dvd_u[W-1];
        q    <= mag;
        rem  <= '0;
        den  <= divisor;
        left <= LW'(W);
      end else if (busy) begin
        rem  <= ge ? (rem_sh - {1'b0, den}) : rem_sh;
        q    <= {q[W-2:0], ge};
        left <= left - LW'(1);
        if (left == LW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== rtl/ppma_back.sv =====
// Back end: point window, sequencer over pending points, accumulator and output register.
// Depends on ppma_pkg and ppma_div.
module ppma_back #(
  parameter int HALF = ppma_pkg::HALF_DEFAULT,
  localparam int DEPTH = 2 * HALF + 2,
  localparam int K_W = $clog2(DEPTH + 1),
  localparam int POS_W = $clog2(DEPTH),
  localparam int CNT_W = $clog2(2 * HALF + 2),
  localparam int SUM_W = ppma_pkg::COORD_W + CNT_W
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         job_valid,
  output logic                         job_ready,
  input  ppma_pkg::point_t             job_point,
  input  logic                         job_last,
  input  logic [K_W-1:0]               job_k,
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [ppma_pkg::TDATA_W-1:0] m_tdata,  // smooth_x, smooth_y, out_heading
  output logic                         m_tlast   // out_last
);
  import ppma_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_SETUP, S_SUM, S_DIV, S_OUT} state_t;

  state_t                    state;
  logic signed [COORD_W-1:0] xw [DEPTH];
  logic signed [COORD_W-1:0] yw [DEPTH];
  logic signed [HEAD_W-1:0]  hw [DEPTH];
  logic [K_W-1:0]            cur_k;
  logic                      cur_last;
  logic [POS_W-1:0]          e;
  logic [POS_W-1:0]          d;
  logic [POS_W-1:0]          hi;
  logic                      pass;
  logic [CNT_W-1:0]          cnt;
  logic signed [SUM_W-1:0]   acc_x;
  logic signed [SUM_W-1:0]   acc_y;
  logic                      div_start;
  logic                      dx_done;
  logic                      dy_done;
  logic signed [SUM_W-1:0]   qx;
  logic signed [SUM_W-1:0]   qy;

  logic [POS_W-1:0]          rd;
  logic signed [COORD_W-1:0] rd_x;
  logic signed [COORD_W-1:0] rd_y;
  logic                      pass_c;
  logic [POS_W-1:0]          lo_c;
  logic [POS_W-1:0]          hi_c;
  logic [POS_W-1:0]          e_hi;
  logic [K_W-1:0]            km1;
  point_t                    res;

  assign job_ready = (state == S_IDLE);

  assign rd   = (state == S_SUM) ? d : e;
  assign rd_x = xw[rd];
  assign rd_y = yw[rd];

  // averaging span, clipped to the interior points held in the window
  assign pass_c = (K_W'(e) == cur_k) || (e == '0);
  assign lo_c   = (e > POS_W'(HALF)) ? (e - POS_W'(HALF)) : POS_W'(1);
  assign e_hi   = e + POS_W'(HALF);
  assign km1    = cur_k - K_W'(1);
  assign hi_c   = (K_W'(e_hi) > km1) ? km1[POS_W-1:0] : e_hi;

  always_comb begin
    res.x       = pass ? rd_x : qx[COORD_W-1:0];
    res.y       = pass ? rd_y : qy[COORD_W-1:0];
    res.heading = hw[e];
  end

  always_ff @(posedge clk) begin
    if (job_valid && job_ready) begin
      for (int i = DEPTH - 1; i > 0; i--) begin
        xw[i] <= xw[i-1];
        yw[i] <= yw[i-1];
        hw[i] <= hw[i-1];
      end
      xw[0] <= job_point.x;
      yw[0] <= job_point.y;
      hw[0] <= job_point.heading;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      m_tvalid  <= 1'b0;
      div_start <= 1'b0;
    end else begin
      div_start <= 1'b0;
      if (m_tready && state != S_OUT) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (job_valid) begin
            cur_k    <= job_k;
            cur_last <= job_last;
            if (job_last) begin
              e     <= (job_k < K_W'(HALF)) ? job_k[POS_W-1:0] : POS_W'(HALF);
              state <= S_SETUP;
            end else if (job_k >= K_W'(HALF + 1)) begin
              e     <= POS_W'(HALF + 1);
              state <= S_SETUP;
            end
          end
        end
        S_SETUP: begin
          pass <= pass_c;
          if (pass_c) begin
            state <= S_OUT;
          end else begin
            d     <= lo_c;
            hi    <= hi_c;
            cnt   <= CNT_W'(hi_c - lo_c + POS_W'(1));
            acc_x <= '0;
            acc_y <= '0;
            state <= S_SUM;
          end
        end
        S_SUM: begin
          acc_x <= acc_x + {{CNT_W{rd_x[COORD_W-1]}}, rd_x};
          acc_y <= acc_y + {{CNT_W{rd_y[COORD_W-1]}}, rd_y};
          if (d == hi) begin
            div_start <= 1'b1;
            state     <= S_DIV;
          end else begin
            d <= d + POS_W'(1);
          end
        end
        S_DIV: begin
          if (dx_done && dy_done) begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= TDATA_W'(res);
            m_tlast  <= cur_last && (e == '0);
            if (cur_last && (e != '0)) begin
              e     <= e - POS_W'(1);
              state <= S_SETUP;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  ppma_div #(
    .W  (SUM_W),
    .DW (CNT_W)
  ) u_div_x (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (acc_x),
    .divisor  (cnt),
    .done     (dx_done),
    .quotient (qx)
  );

  ppma_div #(
    .W  (SUM_W),
    .DW (CNT_W)
  ) u_div_y (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (acc_y),
    .divisor  (cnt),
    .done     (dy_done),
    .quotient (qy)
  );

endmodule

// ===== rtl/path_point_moving_average.sv =====
// Centred moving-average smoother for 2-D path points. Uses ppma_pkg, ppma_front,
// ppma_queue and ppma_back. A point leaves HALF+1 input beats after it arrives.
// Each result is set up and, for a pass-through point, loaded straight into the output register;
// an averaged point first accumulates its span (1 to 2*HALF+1 points) and divides the sum before
// it is loaded. The back end takes no new job until its last result is loaded.
// Synchronous reset clears control and the point count; window contents stay undefined.
module path_point_moving_average #(
  parameter int HALF        = ppma_pkg::HALF_DEFAULT,
  parameter int QUEUE_DEPTH = ppma_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [ppma_pkg::TDATA_W-1:0] s_tdata,  // x_coord, y_coord, heading
  input  logic                         s_tlast,  // is_last
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [ppma_pkg::TDATA_W-1:0] m_tdata,  // smooth_x, smooth_y, out_heading
  output logic                         m_tlast   // out_last
);
  import ppma_pkg::*;

  localparam int DEPTH = 2 * HALF + 2;
  localparam int K_W   = $clog2(DEPTH + 1);
  localparam int JOB_W = POINT_W + 1 + K_W;

  logic             f_valid;
  logic             f_ready;
  point_t           f_point;
  logic             f_last;
  logic [K_W-1:0]   f_k;
  logic [JOB_W-1:0] q_in;
  logic [JOB_W-1:0] q_out;
  logic             b_valid;
  logic             b_ready;
  point_t           b_point;
  logic             b_last;
  logic [K_W-1:0]   b_k;

  assign q_in    = {f_k, f_last, f_point};
  assign b_point = point_t'(q_out[POINT_W-1:0]);
  assign b_last  = q_out[POINT_W];
  assign b_k     = q_out[JOB_W-1:POINT_W+1];

  ppma_front #(
    .HALF (HALF)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .job_valid (f_valid),
    .job_ready (f_ready),
    .job_point (f_point),
    .job_last  (f_last),
    .job_k     (f_k)
  );

  ppma_queue #(
    .W     (JOB_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_valid),
    .in_ready  (f_ready),
    .in_data   (q_in),
    .out_valid (b_valid),
    .out_ready (b_ready),
    .out_data  (q_out)
  );

  ppma_back #(
    .HALF (HALF)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (b_valid),
    .job_ready (b_ready),
    .job_point (b_point),
    .job_last  (b_last),
    .job_k     (b_k),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
  );

  a_count_restarts: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tlast |=> f_k == '0)
    else $error("point count not cleared after last beat");

  a_count_bounded: assert property (@(posedge clk) disable iff (rst)
    f_k <= K_W'(DEPTH))
    else $error("point count beyond window depth");

  a_count_steps: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && !s_tlast && f_k != K_W'(DEPTH) |=> f_k == $past(f_k) + K_W'(1))
    else $error("point count did not advance");

endmodule
